[rtl/core/lfr_pkg.sv]
// Shared constants and types for the layered Fresnel reflectance block.
// Used by lfr_div and layered_fresnel_reflectance; depends on nothing.
`default_nettype none

package lfr_pkg;

  // Default internal fraction width
  localparam int unsigned FRAC_BITS = 16;

  // Field and register widths
  localparam int unsigned Q16_W   = 17;
  localparam int unsigned IOR_W   = 15;
  localparam int unsigned COS_W   = 18;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned IN_TW   = 24;
  localparam int unsigned OUT_TW  = 56;

  // Fixed-point anchors
  localparam logic [Q16_W-1:0] Q16_ONE = 17'd65536;
  localparam logic [IOR_W-1:0] IOR_ONE = 15'd4096;

  // Register reset values
  localparam logic [Q16_W-1:0] RST_WEIGHT = 17'd65536;
  localparam logic [Q16_W-1:0] RST_COLOR  = 17'd52429;
  localparam logic [Q16_W-1:0] RST_METAL  = 17'd0;
  localparam logic [IOR_W-1:0] RST_IOR    = 15'd6144;
  localparam logic [Q16_W-1:0] RST_COAT   = 17'd0;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_BASE_WEIGHT = 3'd0,
    REG_BASE_RED    = 3'd1,
    REG_BASE_GREEN  = 3'd2,
    REG_BASE_BLUE   = 3'd3,
    REG_METAL       = 3'd4,
    REG_SPEC_IOR    = 3'd5,
    REG_COAT_WEIGHT = 3'd6,
    REG_COAT_IOR    = 3'd7
  } cfg_reg_e;

  // Divider status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[rtl/core/lfr_div.sv]
// Bit-serial restoring divider forming (n-1)/(n+1) for a Q3.12 index.
// Depends on lfr_pkg.
`default_nettype none

module lfr_div #(
  parameter int unsigned FRAC_BITS = lfr_pkg::FRAC_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [lfr_pkg::IOR_W-1:0]     ior_i,
  output lfr_pkg::div_stat_t                 stat_o,
  output logic [FRAC_BITS-1:0]               ratio_o
);

  localparam int unsigned DW  = 16 + FRAC_BITS;
  localparam int unsigned CW  = $clog2(DW + 1);
  localparam int unsigned RW  = 17;

  logic [lfr_pkg::IOR_W-1:0] n_cl;
  logic [15:0]               num, den;
  logic [DW-1:0]             dvd_init;
  logic [DW-1:0]             dvd_q, dvd_d;
  logic [DW-1:0]             quo_q, quo_d;
  logic [RW-1:0]             rem_q, rem_d, rem_sh;
  logic [15:0]               den_q, den_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [FRAC_BITS-1:0]      ratio_q, ratio_d;

  // Clamp the index and form numerator and denominator
  always_comb begin
    n_cl     = (ior_i < lfr_pkg::IOR_ONE) ? lfr_pkg::IOR_ONE : ior_i;
    num      = 16'(n_cl - lfr_pkg::IOR_ONE);
    den      = 16'(n_cl) + 16'(lfr_pkg::IOR_ONE);
    dvd_init = (DW'(num) << FRAC_BITS) + DW'(den >> 1);
  end

  // One quotient bit per cycle
  always_comb begin
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    ratio_d = ratio_q;
    rem_sh  = {rem_q[RW-2:0], dvd_q[DW-1]};
    if (start_i) begin
      dvd_d  = dvd_init;
      quo_d  = '0;
      rem_d  = '0;
      den_d  = den;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DW-2:0], 1'b0};
      if (rem_sh >= RW'(den_q)) begin
        rem_d = rem_sh - RW'(den_q);
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        ratio_d = quo_d[FRAC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    ratio_q <= ratio_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign ratio_o     = ratio_q;

  // Counter is zero whenever the divider is idle
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0) else $error("divider count live while idle");
  // Done follows the last busy cycle
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  // Start launches a run
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");

endmodule

`default_nettype wire

[rtl/core/layered_fresnel_reflectance.sv]
// Top level: coated-surface Schlick Fresnel reflectance pipeline.
// Depends on lfr_pkg and lfr_div.
`default_nettype none

// Takes one view cosine per transaction and returns RGB reflectance of the
// configured coated material. The datapath is an eight-stage pipeline that
// accepts one transaction per cycle while the output is drained and input is
// not held off. The two index ratios f0 come from a bit-serial divider: after
// reset and after each write to an index register input is held off until
// both ratios are recomputed and settled; any other register write holds input
// off while derived terms settle.
module layered_fresnel_reflectance #(
  parameter int unsigned FRAC_BITS = lfr_pkg::FRAC_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [lfr_pkg::IDX_W-1:0]     cfg_idx_i,
  input  wire logic [lfr_pkg::CFG_W-1:0]     cfg_data_i,
  // Input stream; tdata: view_cosine[17:0], zero pad
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [lfr_pkg::IN_TW-1:0]     s_axis_tdata,
  // Output stream; tdata: refl_red[16:0], refl_green[33:17], refl_blue[50:34]
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [lfr_pkg::OUT_TW-1:0]         m_axis_tdata
);

  localparam int unsigned W   = FRAC_BITS + 1;
  localparam int unsigned NST = 8;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  // Rounded product of two values in [0,1]
  function automatic logic [W-1:0] fmul(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [2*W-1:0] p;
    p = (2*W)'(a) * (2*W)'(b) + ((2*W)'(1) << (FRAC_BITS - 1));
    return W'(p >> FRAC_BITS);
  endfunction

  // Rounded product with a one-bit wider right operand
  function automatic logic [W:0] fmulw(input logic [W-1:0] a, input logic [W:0] b);
    logic [2*W:0] p;
    p = (2*W+1)'(a) * (2*W+1)'(b) + ((2*W+1)'(1) << (FRAC_BITS - 1));
    return (W+1)'(p >> FRAC_BITS);
  endfunction

  // Q1.16 to internal, saturating at one
  function automatic logic [W-1:0] q16_in(input logic [lfr_pkg::Q16_W-1:0] q);
    logic [lfr_pkg::Q16_W-1:0]      qs;
    logic [lfr_pkg::Q16_W+FRAC_BITS:0] t;
    qs = (q > lfr_pkg::Q16_ONE) ? lfr_pkg::Q16_ONE : q;
    t  = ((lfr_pkg::Q16_W+FRAC_BITS+1)'(qs) << FRAC_BITS)
       + (lfr_pkg::Q16_W+FRAC_BITS+1)'(32768);
    return W'(t >> 16);
  endfunction

  // Internal to Q1.16 output, saturating at one
  function automatic logic [lfr_pkg::Q16_W-1:0] fx_out(input logic [W+1:0] v);
    logic [W-1:0]    vs;
    logic [W+16:0]   t;
    vs = (v > (W+2)'(ONE)) ? ONE : W'(v);
    t  = ((W+17)'(vs) << 16) + ((W+17)'(1) << (FRAC_BITS - 1));
    return lfr_pkg::Q16_W'(t >> FRAC_BITS);
  endfunction

  // ---------------- configuration registers ----------------
  logic [lfr_pkg::Q16_W-1:0] weight_q, metal_q, coatw_q;
  logic [lfr_pkg::Q16_W-1:0] color_q [3];
  logic [lfr_pkg::IOR_W-1:0] spec_ior_q, coat_ior_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q   <= lfr_pkg::RST_WEIGHT;
      color_q[0] <= lfr_pkg::RST_COLOR;
      color_q[1] <= lfr_pkg::RST_COLOR;
      color_q[2] <= lfr_pkg::RST_COLOR;
      metal_q    <= lfr_pkg::RST_METAL;
      spec_ior_q <= lfr_pkg::RST_IOR;
      coatw_q    <= lfr_pkg::RST_COAT;
      coat_ior_q <= lfr_pkg::RST_IOR;
    end else if (cfg_we_i) begin
      case (lfr_pkg::cfg_reg_e'(cfg_idx_i))
        lfr_pkg::REG_BASE_WEIGHT: weight_q   <= cfg_data_i;
        lfr_pkg::REG_BASE_RED:    color_q[0] <= cfg_data_i;
        lfr_pkg::REG_BASE_GREEN:  color_q[1] <= cfg_data_i;
        lfr_pkg::REG_BASE_BLUE:   color_q[2] <= cfg_data_i;
        lfr_pkg::REG_METAL:       metal_q    <= cfg_data_i;
        lfr_pkg::REG_SPEC_IOR:    spec_ior_q <= cfg_data_i[lfr_pkg::IOR_W-1:0];
        lfr_pkg::REG_COAT_WEIGHT: coatw_q    <= cfg_data_i;
        lfr_pkg::REG_COAT_IOR:    coat_ior_q <= cfg_data_i[lfr_pkg::IOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived material terms, refreshed every cycle
  logic [W-1:0] cw_q, w_q, m_q, om_q, a_q;
  logic [W-1:0] col_q [3];
  logic [W-1:0] b_q   [3];
  logic [W-1:0] mc_q  [3];

  always_ff @(posedge clk_i) begin
    cw_q <= q16_in(coatw_q);
    w_q  <= q16_in(weight_q);
    m_q  <= q16_in(metal_q);
    om_q <= ONE - q16_in(metal_q);
    a_q  <= fmul(om_q, w_q);
    for (int c = 0; c < 3; c++) begin
      col_q[c] <= q16_in(color_q[c]);
      mc_q[c]  <= fmul(m_q, col_q[c]);
      b_q[c]   <= fmul(a_q, col_q[c]);
    end
  end

  // ---------------- f0 computation ----------------
  lfr_pkg::div_stat_t   spec_stat, coat_stat;
  logic [FRAC_BITS-1:0] spec_r, coat_r;
  logic [W-1:0]         f0s_q, f0c_q;
  logic                 recalc_q, recalc_d, div_start;
  logic [1:0]           settle_q, settle_d;
  logic                 ior_wr, hold;

  assign ior_wr = cfg_we_i &&
                  (lfr_pkg::cfg_reg_e'(cfg_idx_i) == lfr_pkg::REG_SPEC_IOR ||
                   lfr_pkg::cfg_reg_e'(cfg_idx_i) == lfr_pkg::REG_COAT_IOR);
  assign div_start = recalc_q && !spec_stat.busy;

  lfr_div #(.FRAC_BITS(FRAC_BITS)) u_div_spec (
    .clk_i, .rst_ni, .start_i(div_start), .ior_i(spec_ior_q),
    .stat_o(spec_stat), .ratio_o(spec_r)
  );

  lfr_div #(.FRAC_BITS(FRAC_BITS)) u_div_coat (
    .clk_i, .rst_ni, .start_i(div_start), .ior_i(coat_ior_q),
    .stat_o(coat_stat), .ratio_o(coat_r)
  );

  // Square the ratios
  always_ff @(posedge clk_i) begin
    f0s_q <= fmul(W'(spec_r), W'(spec_r));
    f0c_q <= fmul(W'(coat_r), W'(coat_r));
  end

  // Hold input off while ratios or derived terms settle
  always_comb begin
    recalc_d = (recalc_q && !div_start) || ior_wr;
    settle_d = (cfg_we_i || spec_stat.done) ? 2'd3
             : (settle_q != 2'd0) ? settle_q - 2'd1 : 2'd0;
    hold     = recalc_q || spec_stat.busy || coat_stat.busy || spec_stat.done ||
               coat_stat.done || (settle_q != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recalc_q <= 1'b1;
      settle_q <= 2'd0;
    end else begin
      recalc_q <= recalc_d;
      settle_q <= settle_d;
    end
  end

  // ---------------- datapath pipeline ----------------
  logic [NST-1:0] vld_q;
  logic           en, in_acc;

  assign en            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en && !hold;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_acc};
    end
  end

  logic [lfr_pkg::COS_W-1:0] raw;
  logic [lfr_pkg::Q16_W-1:0] c16;
  logic [W-1:0] x1_q, x2_q, x2x_q, x4_q, x3x_q, x5_q;
  logic [W-1:0] fs_q, fcr_q, fc6_q, sp6_q, fc7_q;
  logic [W-1:0] df6_q [3];
  logic [W:0]   sub_q [3];
  logic [lfr_pkg::Q16_W-1:0] out_q [3];

  // Clamp the cosine to [0,1]
  always_comb begin
    raw = s_axis_tdata[lfr_pkg::COS_W-1:0];
    if (raw[lfr_pkg::COS_W-1]) c16 = '0;
    else if (raw > lfr_pkg::COS_W'(lfr_pkg::Q16_ONE)) c16 = lfr_pkg::Q16_ONE;
    else c16 = raw[lfr_pkg::Q16_W-1:0];
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= ONE - q16_in(c16);
      x2_q  <= fmul(x1_q, x1_q);
      x2x_q <= x1_q;
      x4_q  <= fmul(x2_q, x2_q);
      x3x_q <= x2x_q;
      x5_q  <= fmul(x4_q, x3x_q);
      fs_q  <= f0s_q + fmul(ONE - f0s_q, x5_q);
      fcr_q <= f0c_q + fmul(ONE - f0c_q, x5_q);
      fc6_q <= fmul(cw_q, fcr_q);
      sp6_q <= fmul(om_q, fs_q);
      fc7_q <= fc6_q;
      for (int c = 0; c < 3; c++) begin
        df6_q[c] <= fmul(b_q[c], ONE - fs_q);
        sub_q[c] <= (W+1)'(df6_q[c]) + (W+1)'(mc_q[c]) + (W+1)'(sp6_q);
        out_q[c] <= fx_out((W+2)'(fc7_q) + (W+2)'(fmulw(ONE - fc7_q, sub_q[c])));
      end
    end
  end

  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = {5'd0, out_q[2], out_q[1], out_q[0]};

  // No transaction accepted while the ratios are being recomputed
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !spec_stat.busy && !recalc_q) else $error("input taken during f0 update");
  // Both dividers run in lockstep
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spec_stat.busy == coat_stat.busy) else $error("dividers out of step");
  // Results never exceed one
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_q[0] <= lfr_pkg::Q16_ONE && out_q[1] <= lfr_pkg::Q16_ONE &&
                      out_q[2] <= lfr_pkg::Q16_ONE) else $error("reflectance above one");
  // A stalled pipeline keeps its valid bits
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("valid bits moved during stall");

endmodule

`default_nettype wire

[verif/layered_fresnel_reflectance_test.sv]
// Testbench for layered_fresnel_reflectance: random and directed cosines under
// several material settings, checked against an in-bench fixed-point predictor.
// Depends on lfr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module layered_fresnel_reflectance_test;

  localparam int unsigned FB = lfr_pkg::FRAC_BITS;
  localparam int unsigned Q16_W = lfr_pkg::Q16_W;
  localparam int unsigned COS_W = lfr_pkg::COS_W;
  localparam int unsigned IDX_W = lfr_pkg::IDX_W;
  localparam int unsigned CFG_W = lfr_pkg::CFG_W;
  localparam int unsigned IN_TW = lfr_pkg::IN_TW;
  localparam int unsigned OUT_TW = lfr_pkg::OUT_TW;
  localparam longint unsigned ONE = 64'd1 << FB;
  localparam longint unsigned HALF = 64'd1 << (FB - 1);
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [Q16_W-1:0] blue;
    logic [Q16_W-1:0] green;
    logic [Q16_W-1:0] red;
  } rgb_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TW-1:0] m_axis_tdata;

  // Material copy for the predictor
  longint unsigned mat [8];
  int errors = 0;
  int idle_cycles = 0;
  bit sink_stall_long = 1'b0;

  always #1 clk_i = ~clk_i;

  layered_fresnel_reflectance u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    return (a * b + HALF) >> FB;
  endfunction

  function automatic longint unsigned q16_to_fx(longint unsigned q);
    if (q > 65536) q = 65536;
    return ((q << FB) + 32768) >> 16;
  endfunction

  function automatic longint unsigned schlick(longint unsigned n, longint unsigned ct);
    longint unsigned num, den, r, f0, x, x2, x4, x5;
    n = n & 16'h7FFF;
    if (n < 4096) n = 4096;
    num = n - 4096;
    den = n + 4096;
    r = ((num << FB) + (den >> 1)) / den;
    f0 = fx_mul(r, r);
    x = ONE - ct;
    x2 = fx_mul(x, x);
    x4 = fx_mul(x2, x2);
    x5 = fx_mul(x4, x);
    return f0 + fx_mul(ONE - f0, x5);
  endfunction

  function automatic logic [Q16_W-1:0] shade(longint unsigned color, longint unsigned w,
      longint unsigned m, longint unsigned fs, longint unsigned fc);
    longint unsigned dif, spec, tot;
    dif = fx_mul(fx_mul(fx_mul(ONE - m, w), color), ONE - fs);
    spec = fx_mul(m, color) + fx_mul(ONE - m, fs);
    tot = fc + fx_mul(ONE - fc, dif + spec);
    if (tot > ONE) tot = ONE;
    return Q16_W'(((tot << 16) + HALF) >> FB);
  endfunction

  function automatic rgb_t reflectance(logic [COS_W-1:0] raw);
    longint unsigned c16, ct, fs, fc, w, m;
    rgb_t r;
    if (raw[COS_W-1]) c16 = 0;
    else c16 = (raw > 65536) ? 65536 : raw;
    ct = q16_to_fx(c16);
    fs = schlick(mat[lfr_pkg::REG_SPEC_IOR], ct);
    fc = fx_mul(q16_to_fx(mat[lfr_pkg::REG_COAT_WEIGHT]),
                schlick(mat[lfr_pkg::REG_COAT_IOR], ct));
    w = q16_to_fx(mat[lfr_pkg::REG_BASE_WEIGHT]);
    m = q16_to_fx(mat[lfr_pkg::REG_METAL]);
    r.red = shade(q16_to_fx(mat[lfr_pkg::REG_BASE_RED]), w, m, fs, fc);
    r.green = shade(q16_to_fx(mat[lfr_pkg::REG_BASE_GREEN]), w, m, fs, fc);
    r.blue = shade(q16_to_fx(mat[lfr_pkg::REG_BASE_BLUE]), w, m, fs, fc);
    return r;
  endfunction

  // Scoreboard of pending reflectance results
  class refl_scoreboard;
    rgb_t pending [$];
    int mismatches = 0;

    function void note_cosine(logic [COS_W-1:0] raw);
      pending.push_back(reflectance(raw));
    endfunction

    function void check_result(rgb_t got);
      rgb_t exp_rgb;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      exp_rgb = pending.pop_front();
      if (got !== exp_rgb) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: rgb exp %0d %0d %0d got %0d %0d %0d", exp_rgb.red,
                   exp_rgb.green, exp_rgb.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  refl_scoreboard sb = new();

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Sample both streams at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_cosine(s_axis_tdata[COS_W-1:0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(rgb_t'(m_axis_tdata[3*Q16_W-1:0]));
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Randomize the receiver's ready at the falling edge, or hold it high while sink_stall_long is set
  initial begin
    int hold;
    bit rdy;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (sink_stall_long) begin
        m_axis_tready <= 1'b1;
      end else begin
        rdy = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 30) == 0) begin
          rdy = 1'b0;
          hold = $urandom_range(10, 40);
        end
        m_axis_tready <= rdy;
      end
    end
  end

  // Drive one transaction; valid stays high for a back-to-back follower
  task automatic send_cosine(logic [COS_W-1:0] c, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TW'(c);
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(lfr_pkg::cfg_reg_e idx, longint unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_W'(val);
    if (idx == lfr_pkg::REG_SPEC_IOR || idx == lfr_pkg::REG_COAT_IOR) mat[idx] = val & 16'h7FFF;
    else mat[idx] = val & 17'h1FFFF;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [COS_W-1:0] rand_cosine();
    case ($urandom_range(0, 5))
      0: return COS_W'($urandom_range(0, 2 ** COS_W - 1));
      1: return COS_W'($urandom_range(65530, 65536));
      2: return COS_W'($urandom_range(0, 8));
      default: return COS_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic longint unsigned rand_q16();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic longint unsigned rand_ior();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 4096);
      1: return 32767;
      default: return $urandom_range(4096, 12288);
    endcase
  endfunction

  initial begin
    logic [COS_W-1:0] dir [$];
    mat[lfr_pkg::REG_BASE_WEIGHT] = lfr_pkg::RST_WEIGHT;
    mat[lfr_pkg::REG_BASE_RED] = lfr_pkg::RST_COLOR;
    mat[lfr_pkg::REG_BASE_GREEN] = lfr_pkg::RST_COLOR;
    mat[lfr_pkg::REG_BASE_BLUE] = lfr_pkg::RST_COLOR;
    mat[lfr_pkg::REG_METAL] = lfr_pkg::RST_METAL;
    mat[lfr_pkg::REG_SPEC_IOR] = lfr_pkg::RST_IOR;
    mat[lfr_pkg::REG_COAT_WEIGHT] = lfr_pkg::RST_COAT;
    mat[lfr_pkg::REG_COAT_IOR] = lfr_pkg::RST_IOR;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero, one, above one, negative, extremes of the field
    dir = '{18'd0, 18'd65536, 18'd65537, 18'h1FFFF, 18'h20000, 18'h3FFFF,
            18'd1, 18'd32768, 18'd65535, 18'h2AAAA, 18'h15555};
    foreach (dir[i]) send_cosine(dir[i], 1'b0);
    drain();

    // Coated metal with color above one, a coat index below one and the largest spec index
    write_reg(lfr_pkg::REG_METAL, 65536);
    write_reg(lfr_pkg::REG_COAT_WEIGHT, 65536);
    write_reg(lfr_pkg::REG_COAT_IOR, 0);
    write_reg(lfr_pkg::REG_SPEC_IOR, 32767);
    write_reg(lfr_pkg::REG_BASE_RED, 131071);
    write_reg(lfr_pkg::REG_BASE_GREEN, 0);
    write_reg(lfr_pkg::REG_BASE_BLUE, 65536);
    write_reg(lfr_pkg::REG_BASE_WEIGHT, 131071);
    foreach (dir[i]) send_cosine(dir[i], 1'b0);
    drain();

    // Random phases with fresh material settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(lfr_pkg::REG_BASE_WEIGHT, rand_q16());
      write_reg(lfr_pkg::REG_BASE_RED, rand_q16());
      write_reg(lfr_pkg::REG_BASE_GREEN, rand_q16());
      write_reg(lfr_pkg::REG_BASE_BLUE, rand_q16());
      write_reg(lfr_pkg::REG_METAL, rand_q16());
      write_reg(lfr_pkg::REG_SPEC_IOR, rand_ior());
      write_reg(lfr_pkg::REG_COAT_WEIGHT, rand_q16());
      write_reg(lfr_pkg::REG_COAT_IOR, rand_ior());
      sink_stall_long = (ph == 3);
      for (int k = 0; k < 80; k++) begin
        send_cosine(rand_cosine(), (ph % 3) != 1);
        // Pause until every pending result is out
        if (k == 40 && ph == 5) begin
          s_axis_tvalid <= 1'b0;
          while (sb.pending.size() != 0) @(negedge clk_i);
          @(negedge clk_i);
        end
      end
      sink_stall_long = 1'b0;
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
